@@ rtl/ufb_pkg.sv @@
`timescale 1ns / 1ps

package ufb_pkg;

  // Field widths fixed by the register map and the item format
  localparam int WAIT_W  = 24;
  localparam int BYTE_W  = 8;
  localparam int ELAP_W  = 16;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_A_W = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_WR_DROPPED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RD_EMPTY   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_READ_WAIT  = 1'd0;
  localparam logic [CFG_A_W-1:0] CFG_WRITE_WAIT = 1'd1;

  // Reset value of both pacing registers
  localparam logic [WAIT_W-1:0] WAIT_RESET = 24'd60000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] write_data;
    logic [ELAP_W-1:0] elapsed_cycles;
    logic              partner_accepting;
    logic              partner_has_byte;
    logic [BYTE_W-1:0] partner_byte;
  } ufb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              to_partner_valid;
    logic [BYTE_W-1:0] to_partner_byte;
    logic              partner_byte_taken;
    logic              write_ready;
    logic              read_ready;
    logic [STAT_W-1:0] status;
  } ufb_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted input transaction
    logic update;   // commit ring/countdown state and load the result
  } ufb_ctrl_t;

endpackage

@@ rtl/ufb_ram.sv @@
`timescale 1ns / 1ps

module ufb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/ufb_ctrl.sv @@
`timescale 1ns / 1ps

module ufb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output ufb_pkg::ufb_ctrl_t ctrl
);

  import ufb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // Output register can take a new result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctrl.capture  = 1'b0;
    ctrl.update   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      // ring RAM read data settles here
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl.update   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/ufb_datapath.sv @@
`timescale 1ns / 1ps

module ufb_datapath #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ufb_pkg::ufb_ctrl_t                  ctrl,
  input  ufb_pkg::ufb_in_t                    in_data,
  input  logic                                cfg_we,
  input  logic [ufb_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [ufb_pkg::WAIT_W-1:0]          cfg_data,
  output ufb_pkg::ufb_out_t                   out_data
);

  import ufb_pkg::*;

  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);
  localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);

  // Pacing registers
  logic [WAIT_W-1:0] read_wait_r, write_wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_wait_r  <= WAIT_RESET;
      write_wait_r <= WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_READ_WAIT:  read_wait_r  <= cfg_data;
        CFG_WRITE_WAIT: write_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured input transaction
  ufb_in_t in_r;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      in_r <= in_data;
    end
  end

  // Ring pointers and countdowns
  logic [TX_PW-1:0]  tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [RX_PW-1:0]  rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [WAIT_W-1:0] read_cd_r, read_cd_nxt, write_cd_r, write_cd_nxt;
  ufb_out_t          out_r, out_nxt;

  logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;
  logic              tx_wr_en, rx_wr_en;

  logic [TX_PW-1:0]  tx_head_inc, tx_tail_inc;
  logic [RX_PW-1:0]  rx_head_inc, rx_tail_inc;
  logic [WAIT_W-1:0] elapsed_ext;
  logic              tx_full, tx_empty, rx_room, rx_empty;

  assign tx_head_inc = (tx_head_r == TX_LAST) ? '0 : tx_head_r + 1'b1;
  assign tx_tail_inc = (tx_tail_r == TX_LAST) ? '0 : tx_tail_r + 1'b1;
  assign rx_head_inc = (rx_head_r == RX_LAST) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_inc = (rx_tail_r == RX_LAST) ? '0 : rx_tail_r + 1'b1;

  // A ring holds at most depth minus one bytes
  assign tx_full  = (tx_head_inc == tx_tail_r);
  assign tx_empty = (tx_head_r == tx_tail_r);
  assign rx_room  = (rx_head_inc != rx_tail_r);
  assign rx_empty = (rx_head_r == rx_tail_r);

  assign elapsed_ext = {{(WAIT_W-ELAP_W){1'b0}}, in_r.elapsed_cycles};

  always_comb begin
    tx_head_nxt  = tx_head_r;
    tx_tail_nxt  = tx_tail_r;
    rx_head_nxt  = rx_head_r;
    rx_tail_nxt  = rx_tail_r;
    read_cd_nxt  = read_cd_r;
    write_cd_nxt = write_cd_r;
    tx_wr_en     = 1'b0;
    rx_wr_en     = 1'b0;
    out_nxt      = '0;
    case (in_r.cmd)
      CMD_TICK: begin
        // send, receive, count down; read wait if rx nonempty
        if (in_r.partner_accepting && !tx_empty) begin
          out_nxt.to_partner_valid = 1'b1;
          out_nxt.to_partner_byte  = tx_rd_data;
          tx_tail_nxt              = tx_tail_inc;
        end
        if (in_r.partner_has_byte && rx_room) begin
          rx_wr_en                   = ctrl.update;
          rx_head_nxt                = rx_head_inc;
          out_nxt.partner_byte_taken = 1'b1;
        end
        if (rx_head_nxt != rx_tail_r) begin
          read_cd_nxt = (read_cd_r <= elapsed_ext) ? '0 : read_cd_r - elapsed_ext;
        end
        write_cd_nxt = (write_cd_r <= elapsed_ext) ? '0 : write_cd_r - elapsed_ext;
      end
      CMD_WRITE: begin
        if (tx_full) begin
          out_nxt.status = STAT_WR_DROPPED;
        end else begin
          tx_wr_en     = ctrl.update;
          tx_head_nxt  = tx_head_inc;
          write_cd_nxt = write_wait_r;
        end
      end
      CMD_READ: begin
        if (rx_empty) begin
          out_nxt.status = STAT_RD_EMPTY;
        end else begin
          out_nxt.read_data = rx_rd_data;
          rx_tail_nxt       = rx_tail_inc;
          read_cd_nxt       = read_wait_r;
        end
      end
      default: ;
    endcase
    out_nxt.write_ready = (write_cd_nxt == '0);
    out_nxt.read_ready  = (read_cd_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
      rx_head_r  <= '0;
      rx_tail_r  <= '0;
      read_cd_r  <= '0;
      write_cd_r <= '0;
    end else if (ctrl.update) begin
      tx_head_r  <= tx_head_nxt;
      tx_tail_r  <= tx_tail_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_tail_r  <= rx_tail_nxt;
      read_cd_r  <= read_cd_nxt;
      write_cd_r <= write_cd_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // Ring storage; read ports always sit on the read index
  ufb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk     (clk),
    .wr_en   (tx_wr_en),
    .wr_addr (tx_head_r),
    .wr_data (in_r.write_data),
    .rd_addr (tx_tail_r),
    .rd_data (tx_rd_data)
  );

  ufb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk     (clk),
    .wr_en   (rx_wr_en),
    .wr_addr (rx_head_r),
    .wr_data (in_r.partner_byte),
    .rd_addr (rx_tail_r),
    .rd_data (rx_rd_data)
  );

endmodule

@@ rtl/uart_fifo_bridge_with_pacing.sv @@
`timescale 1ns / 1ps

// UART bridge with a transmit ring and a receive ring, each holding up to
// depth minus one bytes, plus read and write pacing countdowns. Each input
// transaction is a tick (hand one byte to the partner, take one from it,
// count the waits down), a processor write or a processor read, and yields
// exactly one result transaction. An item passes from acceptance through a
// registered ring RAM read at the read index to the state update that loads
// the output register once any held result is taken; the next item is
// accepted only after that update. The output register holds a result while
// the next item is being worked on. The rings need no clearing after reset.
// Write the pacing registers only while the block is idle.
module uart_fifo_bridge_with_pacing #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ufb_pkg::ufb_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ufb_pkg::ufb_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [ufb_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [ufb_pkg::WAIT_W-1:0]  cfg_data
);

  import ufb_pkg::*;

  ufb_ctrl_t ctrl;

  // Sequencer and handshake
  ufb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // Rings, pointers, countdowns and result register
  ufb_datapath #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule
